FILE: hdl/pet_pkg.sv
// shared types, constants and codes of the page error tracker
`default_nettype none
package pet_pkg;
	localparam int ENTRIES    = 64;
	localparam int IDX_BITS   = $clog2(ENTRIES);
	localparam int OCC_BITS   = $clog2(ENTRIES + 1);
	localparam int PAGE_BITS  = 40;
	localparam int COUNT_BITS = 16;
	localparam int TS_BITS    = 48;
	localparam int STAMP_BITS = 48;
	localparam int CFG_BITS   = 48;
	localparam int CIDX_BITS  = 3;
	localparam int IN_BYTES_W = 96;
	localparam int OUT_W      = 24;

	typedef logic [IDX_BITS-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_CE       = 2'd0,
		OP_DEFERRED = 2'd1,
		OP_CONSUMED = 2'd2,
		OP_COMPLETE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_WATCHED  = 3'd0,
		ST_PRE_ISO  = 3'd1,
		ST_PRE_FAIL = 3'd2,
		ST_POISONED = 3'd3,
		ST_OFFLINED = 3'd4,
		ST_FAILED   = 3'd5
	} pstate_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_SOFT = 2'd1,
		ACT_HARD = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		EV_ERROR    = 2'd0,
		EV_OFFLINED = 2'd1,
		EV_FAILED   = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_THRESH   = 3'd1,
		REG_WINDOW   = 3'd2,
		REG_PRE_ISO  = 3'd3,
		REG_SOFT_OK  = 3'd4
	} reg_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic                 success;
		logic                 was_soft;
		logic                 triaged;
		logic                 hw_poisoned;
		logic                 page_valid;
		logic [TS_BITS-1:0]   now;
		logic [PAGE_BITS-1:0] page;
		logic [1:0]           op;
	} in_item_t;

	typedef struct packed {
		logic        tracked;
		logic [1:0]  event_kind;
		logic [1:0]  action;
		logic [15:0] error_count;
		logic [2:0]  pg_state;
	} out_item_t;

	typedef struct packed {
		logic [STAMP_BITS-1:0] stamp;
		logic [TS_BITS-1:0]    win_start;
		logic [COUNT_BITS-1:0] count;
		logic [2:0]            state;
		logic [PAGE_BITS-1:0]  page;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic exec;
		idx_t addr;
	} cmd_t;

	typedef struct packed {
		logic out_blocked;
	} status_t;
endpackage
`default_nettype wire

FILE: hdl/pet_ram.sv
// generic single-port ram with registered read
`default_nettype none
module pet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: hdl/pet_ctrl.sv
// controller: input handshake and table scan sequencing
`default_nettype none
module pet_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pet_pkg::status_t status,
	output pet_pkg::cmd_t         cmd
);
	pet_pkg::fsm_t state_q, state_d;
	pet_pkg::idx_t cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pet_pkg::FSM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.addr = cnt_q;
		case (state_q)
			pet_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = pet_pkg::FSM_SCAN;
				end
			end
			pet_pkg::FSM_SCAN: begin
				cmd.rd = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == pet_pkg::idx_t'(pet_pkg::ENTRIES - 1)) begin
					state_d = pet_pkg::FSM_DRAIN;
				end
			end
			pet_pkg::FSM_DRAIN: begin
				state_d = pet_pkg::FSM_EXEC;
			end
			pet_pkg::FSM_EXEC: begin
				if (!status.out_blocked) begin
					cmd.exec = 1'b1;
					state_d  = pet_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = pet_pkg::FSM_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: hdl/pet_dp.sv
// datapath: table ram, valid bits, scan accumulators, update and result register
`default_nettype none
module pet_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pet_pkg::cmd_t                 cmd,
	output pet_pkg::status_t                   status,
	input  wire pet_pkg::in_item_t             in_data,
	input  wire logic                          cfg_we,
	input  wire logic [pet_pkg::CIDX_BITS-1:0] cfg_index,
	input  wire logic [pet_pkg::CFG_BITS-1:0]  cfg_wdata,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pet_pkg::OUT_W-1:0]          out_data
);
	localparam logic [pet_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

	// configuration
	logic                         enable_q, pre_iso_q, soft_ok_q;
	logic [15:0]                  thresh_q;
	logic [pet_pkg::TS_BITS-1:0]  window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			thresh_q  <= 16'd16;
			window_q  <= pet_pkg::TS_BITS'(86400);
			pre_iso_q <= 1'b1;
			soft_ok_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				pet_pkg::REG_ENABLE:  enable_q  <= cfg_wdata[0];
				pet_pkg::REG_THRESH:  thresh_q  <= cfg_wdata[15:0];
				pet_pkg::REG_WINDOW:  window_q  <= cfg_wdata[pet_pkg::TS_BITS-1:0];
				pet_pkg::REG_PRE_ISO: pre_iso_q <= cfg_wdata[0];
				pet_pkg::REG_SOFT_OK: soft_ok_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// captured item
	pet_pkg::in_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	// table ram
	pet_pkg::entry_t rd_ent, wr_ent;
	pet_pkg::idx_t   wr_idx, ram_addr;
	logic            wr_en;

	assign ram_addr = (cmd.exec && wr_en) ? wr_idx : cmd.addr;

	pet_ram #(
		.WIDTH($bits(pet_pkg::entry_t)),
		.DEPTH(pet_pkg::ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.exec && wr_en),
		.addr (ram_addr),
		.wdata(wr_ent),
		.rdata(rd_ent)
	);

	// scan pipeline
	logic            rd_s1;
	pet_pkg::idx_t   idx_s1;
	logic [pet_pkg::ENTRIES-1:0] valid_q;

	logic                            match_q, free_q, vic_q;
	pet_pkg::idx_t                   match_idx_q, free_idx_q, vic_idx_q;
	pet_pkg::entry_t                 match_ent_q;
	logic [pet_pkg::STAMP_BITS-1:0]  vic_stamp_q;

	logic cur_valid, eligible;
	assign cur_valid = valid_q[idx_s1];
	assign eligible  = cur_valid && (rd_ent.state != pet_pkg::ST_PRE_ISO) &&
		(rd_ent.state != pet_pkg::ST_POISONED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			idx_s1  <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			vic_q   <= 1'b0;
		end else begin
			rd_s1  <= cmd.rd;
			idx_s1 <= cmd.addr;
			if (cmd.load) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
				vic_q   <= 1'b0;
			end else if (rd_s1) begin
				if (cur_valid && rd_ent.page == item_q.page && !match_q) begin
					match_q <= 1'b1;
				end
				if (!cur_valid && !free_q) begin
					free_q <= 1'b1;
				end
				if (eligible && (!vic_q || rd_ent.stamp < vic_stamp_q)) begin
					vic_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (cur_valid && rd_ent.page == item_q.page && !match_q) begin
				match_idx_q <= idx_s1;
				match_ent_q <= rd_ent;
			end
			if (!cur_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (eligible && (!vic_q || rd_ent.stamp < vic_stamp_q)) begin
				vic_idx_q   <= idx_s1;
				vic_stamp_q <= rd_ent.stamp;
			end
		end
	end

	// update
	logic [pet_pkg::OCC_BITS-1:0]   occ_q, occ_d;
	logic [pet_pkg::STAMP_BITS-1:0] stamp_q;
	logic                           stamp_inc, produce, clr_valid, set_valid;
	pet_pkg::out_item_t             res;
	pet_pkg::entry_t                ent;
	logic                           have;
	logic [pet_pkg::TS_BITS-1:0]    age;

	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = match_idx_q;
		wr_ent    = match_ent_q;
		ent       = match_ent_q;
		have      = 1'b0;
		stamp_inc = 1'b0;
		produce   = 1'b0;
		clr_valid = 1'b0;
		set_valid = 1'b0;
		occ_d     = occ_q;
		age       = '0;
		res       = '0;
		if (item_q.op == pet_pkg::OP_COMPLETE) begin
			produce      = 1'b1;
			res.pg_state = item_q.success ? pet_pkg::ST_OFFLINED :
				(item_q.was_soft ? pet_pkg::ST_PRE_FAIL : pet_pkg::ST_FAILED);
			res.event_kind = item_q.success ? pet_pkg::EV_OFFLINED : pet_pkg::EV_FAILED;
			if (match_q) begin
				res.tracked     = 1'b1;
				res.error_count = 16'(match_ent_q.count);
				if (item_q.success) begin
					clr_valid = 1'b1;
					occ_d     = occ_q - 1'b1;
				end else begin
					wr_en        = 1'b1;
					wr_ent.state = res.pg_state;
				end
			end
		end else if (enable_q && item_q.page_valid) begin
			produce = 1'b1;
			// slot lookup or allocation
			if (match_q) begin
				have = 1'b1;
			end else if (occ_q == pet_pkg::OCC_BITS'(pet_pkg::ENTRIES)) begin
				have   = vic_q;
				wr_idx = vic_idx_q;
			end else begin
				have   = 1'b1;
				wr_idx = free_idx_q;
				occ_d  = occ_q + 1'b1;
			end
			if (!match_q) begin
				ent.page      = item_q.page;
				ent.state     = pet_pkg::ST_WATCHED;
				ent.count     = '0;
				ent.win_start = item_q.now;
			end
			ent.stamp = stamp_q;
			if (!have) begin
				occ_d = occ_q;
			end
			if (item_q.op == pet_pkg::OP_CE) begin
				res.pg_state    = pet_pkg::ST_WATCHED;
				res.error_count = 16'd1;
				if (have) begin
					age = item_q.now - ent.win_start;
					if (age > window_q) begin
						ent.count     = '0;
						ent.win_start = item_q.now;
					end
					if (ent.count < COUNT_MAX) begin
						ent.count = ent.count + 1'b1;
					end
					if (32'(ent.count) >= 32'(thresh_q) &&
						ent.state == pet_pkg::ST_WATCHED && pre_iso_q && soft_ok_q) begin
						ent.state  = pet_pkg::ST_PRE_ISO;
						res.action = pet_pkg::ACT_SOFT;
					end
					res.error_count = 16'(ent.count);
					res.pg_state    = ent.state;
				end
			end else begin
				res.pg_state = pet_pkg::ST_POISONED;
				if (have) begin
					res.error_count = 16'(ent.count);
					if (ent.state == pet_pkg::ST_WATCHED || ent.state == pet_pkg::ST_PRE_FAIL) begin
						ent.state = pet_pkg::ST_POISONED;
						if (!item_q.hw_poisoned && !item_q.triaged) begin
							res.action = pet_pkg::ACT_HARD;
						end
					end
					res.pg_state = ent.state;
				end else if (!item_q.hw_poisoned && !item_q.triaged) begin
					res.action = pet_pkg::ACT_HARD;
				end
			end
			if (have) begin
				res.tracked = 1'b1;
				wr_en       = 1'b1;
				wr_ent      = ent;
				set_valid   = 1'b1;
				stamp_inc   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			occ_q     <= '0;
			stamp_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.exec && produce) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.exec) begin
				occ_q <= occ_d;
				if (clr_valid) begin
					valid_q[match_idx_q] <= 1'b0;
				end
				if (set_valid) begin
					valid_q[wr_idx] <= 1'b1;
				end
				if (stamp_inc) begin
					stamp_q <= stamp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && produce) begin
			out_data <= res;
		end
	end

	assign status.out_blocked = out_valid && !out_ready;
endmodule
`default_nettype wire

FILE: hdl/page_error_tracker.sv
// top level of the page error tracker
// usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one report or completion item, the
//   operation code in s_tuser; s_tready is high only while the block is idle,
//   so items are handled one at a time
//   m_tvalid/m_tready/m_tdata/m_tuser carry zero or one result item per input
//   item, the event kind in m_tuser; cfg_we/cfg_index/cfg_wdata write the five
//   settings; the user writes them only while idle, the block does not check
// timing:
//   after its item is accepted, a scan of the 64 entries of the ram (one entry
//   per cycle through its single port) finds a matching page, the lowest free
//   slot and the least recent evictable slot; then a drain step and an update
//   step that writes the entry back or clears its valid bit; any result is
//   valid in the cycle after the update, and s_tready returns in that same
//   cycle, so one item is finished before the next is taken
// reset:
//   arst_n clears the valid bits, the occupancy count and the settings to
//   their defaults at once; entry contents are left as they are
// stall:
//   a waiting result sits in the output register while the next item scans;
//   the update step of that next item waits until the register is free
`default_nettype none
module page_error_tracker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// page, now, page_valid, hw_poisoned, triaged, was_soft, success
	input  wire logic [pet_pkg::IN_BYTES_W-1:0] s_tdata,
	// op
	input  wire logic [1:0]                     s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// pg_state, error_count, action, tracked
	output logic [pet_pkg::OUT_W-1:0]           m_tdata,
	// event_kind
	output logic [1:0]                          m_tuser,
	input  wire logic                           cfg_we,
	input  wire logic [pet_pkg::CIDX_BITS-1:0]  cfg_index,
	input  wire logic [pet_pkg::CFG_BITS-1:0]   cfg_wdata
);
	pet_pkg::cmd_t      cmd;
	pet_pkg::status_t   status;
	pet_pkg::in_item_t  in_item;
	pet_pkg::out_item_t out_item;

	// item fields with the operation code in the lowest bits
	assign in_item = {s_tdata[$bits(pet_pkg::in_item_t)-3:0], s_tuser};

	// result fields split between data and kind
	assign m_tdata = {2'b00, out_item.tracked, out_item.action, out_item.error_count,
		out_item.pg_state};
	assign m_tuser = out_item.event_kind;

	// sequencing of load, scan and update
	pet_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// table and result logic
	pet_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (in_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_item)
	);
endmodule
`default_nettype wire

FILE: hdl/pet_checker.sv
// port-level checker of the page error tracker and its bind
`default_nettype none
module pet_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [pet_pkg::OUT_W-1:0]      m_tdata,
	input wire logic [1:0]                     m_tuser
);
	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// completion results never request an offline
	a_cmp_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pet_pkg::EV_ERROR |-> m_tdata[20:19] == pet_pkg::ACT_NONE)
		else $error("completion with action");

	// soft offline only for a tracked page
	a_soft_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20:19] == pet_pkg::ACT_SOFT |-> m_tdata[21])
		else $error("soft offline for untracked page");
endmodule

bind page_error_tracker pet_checker u_pet_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire
